// File: sv/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 8;
  localparam int OCC_W        = 5;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_WR,
    S_SR_RD,
    S_SR_CMP
  } state_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

endpackage

// File: sv/sle_mem.sv
`timescale 1ns / 1ps

module sle_mem #(
  parameter int DEPTH = sle_pkg::CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [sle_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]                   raddr,
  output logic signed [sle_pkg::VAL_W-1:0] rdata
);

  logic signed [sle_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sle_ctrl.sv
`timescale 1ns / 1ps

module sle_ctrl #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  sle_pkg::cmd_t                    cmd,
  output logic                             done,
  output sle_pkg::rsp_t                    rsp,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic signed [sle_pkg::VAL_W-1:0] mem_wdata,
  output logic [AW-1:0]                    mem_raddr,
  input  logic signed [sle_pkg::VAL_W-1:0] mem_rdata
);

  localparam int CMPW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;

  sle_pkg::state_t                  state, state_next;
  logic [CW-1:0]                    count, count_next;
  logic [CW-1:0]                    idx, idx_next;
  logic [CW-1:0]                    idx_inc;
  logic signed [sle_pkg::VAL_W-1:0] key, key_next;
  logic                             done_next;
  sle_pkg::rsp_t                    rsp_next;

  assign idx_inc = idx + 1'b1;
  assign busy    = (state != sle_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sle_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    key <= key_next;
    rsp <= rsp_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    key_next   = key;
    done_next  = 1'b0;
    rsp_next   = rsp;
    mem_we     = 1'b0;
    mem_waddr  = idx[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = idx[AW-1:0];

    unique case (state)
      sle_pkg::S_IDLE: begin
        if (start) begin
          rsp_next.status    = sle_pkg::STAT_OK;
          rsp_next.found     = 1'b0;
          rsp_next.occupancy = sle_pkg::OCC_W'(count);
          unique case (cmd.mode)
            sle_pkg::MODE_APPEND: begin
              done_next = 1'b1;
              if (count < CW'(CAPACITY)) begin
                mem_we             = 1'b1;
                mem_waddr          = count[AW-1:0];
                mem_wdata          = cmd.item_value;
                count_next         = count + 1'b1;
                rsp_next.occupancy = sle_pkg::OCC_W'(count + 1'b1);
              end else begin
                rsp_next.status = sle_pkg::STAT_FULL;
              end
            end
            sle_pkg::MODE_REMOVE: begin
              if (CMPW'(cmd.position) < CMPW'(count)) begin
                idx_next   = CW'(cmd.position);
                state_next = sle_pkg::S_RM_RD;
              end else begin
                done_next       = 1'b1;
                rsp_next.status = sle_pkg::STAT_RANGE;
              end
            end
            sle_pkg::MODE_SEARCH: begin
              key_next = cmd.item_value;
              idx_next = '0;
              if (count == '0) begin
                done_next = 1'b1;
              end else begin
                state_next = sle_pkg::S_SR_RD;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      sle_pkg::S_RM_RD: begin
        if (idx_inc < count) begin
          mem_raddr  = idx_inc[AW-1:0];
          state_next = sle_pkg::S_RM_WR;
        end else begin
          count_next         = count - 1'b1;
          rsp_next.occupancy = sle_pkg::OCC_W'(count - 1'b1);
          done_next          = 1'b1;
          state_next         = sle_pkg::S_IDLE;
        end
      end
      sle_pkg::S_RM_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = mem_rdata;
        idx_next   = idx_inc;
        state_next = sle_pkg::S_RM_RD;
      end
      sle_pkg::S_SR_RD: begin
        state_next = sle_pkg::S_SR_CMP;
      end
      sle_pkg::S_SR_CMP: begin
        if (mem_rdata == key) begin
          rsp_next.found = 1'b1;
          done_next      = 1'b1;
          state_next     = sle_pkg::S_IDLE;
        end else if (idx_inc < count) begin
          idx_next   = idx_inc;
          state_next = sle_pkg::S_SR_RD;
        end else begin
          done_next  = 1'b1;
          state_next = sle_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/static_list_engine.sv
`timescale 1ns / 1ps
// Append, unused modes, rejected commands and a search of an empty list strobe done in the
// cycle after the transfer. Remove alternates S_RM_RD and S_RM_WR to copy each later entry
// one slot down; search alternates S_SR_RD and S_SR_CMP from slot 0 to the first match or end.
// The engine takes no new command while busy; busy drops in the done cycle, so the next
// transfer may land there. The single memory read port paces each step.
// Reset (rst, synchronous): list empties, no result pending; done is a strobe, never held off.
module static_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sle_pkg::cmd_t cmd,
  output logic          done,
  output sle_pkg::rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic signed [sle_pkg::VAL_W-1:0] mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic signed [sle_pkg::VAL_W-1:0] mem_rdata;

  sle_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .rsp      (rsp),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  sle_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// File: sv/sle_chk.sv
`timescale 1ns / 1ps

module sle_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input sle_pkg::cmd_t cmd,
  input logic          done,
  input sle_pkg::rsp_t rsp
);

  a_append_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode == sle_pkg::MODE_APPEND |=> done)
    else $error("append did not complete in one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == sle_pkg::STAT_OK || rsp.status == sle_pkg::STAT_FULL ||
              rsp.status == sle_pkg::STAT_RANGE))
    else $error("unknown status code");

  a_found_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != sle_pkg::STAT_OK |-> !rsp.found)
    else $error("found set on a failed command");

endmodule

bind static_list_engine sle_chk u_sle_chk (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .cmd  (cmd),
  .done (done),
  .rsp  (rsp)
);
